FILE: rtl/core/bwsm_pkg.sv
// Package for the wheel speed mixer: sizes, register map, sensor weights.
// Used by braitenberg_wheel_speed_mixer; depends on nothing.
package bwsm_pkg;

    localparam int SENSOR_LANES   = 8;
    localparam int SENSOR_COUNT_D = 8;
    localparam int DIST_W         = 16;
    localparam int DET_FRAC       = 12;
    localparam int DET_W          = DET_FRAC + 1;
    localparam int PROD_W         = 18;
    localparam int SUM_W          = 20;
    localparam int SPEED_W        = 16;
    localparam int THR_W          = 15;
    localparam int ADDR_W         = 4;

    localparam logic [16:0] RECIP5    = 17'd52429;
    localparam int          RECIP_SH  = 18;
    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(80);

    typedef enum logic [1:0] {
        REG_NO_DETECT  = 2'd0,
        REG_MIN_DETECT = 2'd1,
        REG_BASE_SPEED = 2'd2,
        REG_THRESHOLD  = 2'd3
    } reg_idx_t;

    typedef logic signed [5:0] weight_t;

    localparam weight_t LEFT_WEIGHT [SENSOR_LANES] =
        '{-6'sd2, -6'sd4, -6'sd6, -6'sd8, -6'sd10, -6'sd12, -6'sd14, -6'sd16};
    localparam weight_t RIGHT_WEIGHT [SENSOR_LANES] =
        '{-6'sd16, -6'sd14, -6'sd12, -6'sd10, -6'sd8, -6'sd6, -6'sd4, -6'sd2};

endpackage

FILE: rtl/core/braitenberg_wheel_speed_mixer.sv
// Top level of the wheel speed mixer: APB registers and the full pipeline.
// Depends on bwsm_pkg.
//
//  port group      dir  beat contents
//  s_axis_*        in   tdata: dist_0..dist_7 (16b each), valid_mask (8b)
//  m_axis_*        out  tdata: left_speed (16b), right_speed (16b)
//  APB             in   regs 0..3 at byte 0,4,8,12
//
// One beat per cycle while the pipeline is not stalled.
// Depth is set by the 13-step restoring divider, one step per stage.
// Stall: all stages hold while the output register is full and not taken.
// Reset clears valid bits and loads the register reset values.
module braitenberg_wheel_speed_mixer #(
    parameter int SENSOR_COUNT = bwsm_pkg::SENSOR_COUNT_D
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // dist_0 [15:0] .. dist_7 [127:112], valid_mask [135:128]
    input  logic [135:0]                s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // left_speed [15:0], right_speed [31:16]
    output logic [31:0]                 m_axis_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bwsm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import bwsm_pkg::*;

    localparam int NL = SENSOR_LANES;

    logic [15:0]        nd_reg, mn_reg;
    logic signed [15:0] base_reg;
    logic [THR_W-1:0]   thr_reg;
    reg_idx_t           widx;

    assign pready = 1'b1;
    assign widx   = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nd_reg   <= 16'd1229;
            mn_reg   <= 16'd410;
            base_reg <= 16'sd384;
            thr_reg  <= THR_W'(26);
        end
        else if (psel && penable && pwrite)
        begin
            case (widx)
                REG_NO_DETECT:  nd_reg   <= pwdata[15:0];
                REG_MIN_DETECT: mn_reg   <= pwdata[15:0];
                REG_BASE_SPEED: base_reg <= pwdata[15:0];
                REG_THRESHOLD:  thr_reg  <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (widx)
            REG_NO_DETECT:  prdata = {16'd0, nd_reg};
            REG_MIN_DETECT: prdata = {16'd0, mn_reg};
            REG_BASE_SPEED: prdata = {16'd0, base_reg};
            REG_THRESHOLD:  prdata = {17'd0, thr_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // pipeline advance
    logic en;
    logic out_vld_reg;
    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    logic        span_ok;
    logic [15:0] span;
    assign span_ok = nd_reg > mn_reg;
    assign span    = nd_reg - mn_reg;

    // stage 1: numerator per lane
    logic        v1_reg;
    logic [15:0] num_reg [NL];
    logic [15:0] num_next [NL];

    always_comb
    begin
        logic [15:0] d;
        logic [15:0] dc;
        d  = '0;
        dc = '0;
        for (int i = 0; i < NL; i++)
        begin
            d  = s_axis_tdata[i*DIST_W +: DIST_W];
            dc = (d < mn_reg) ? mn_reg : d;
            if (span_ok && s_axis_tdata[NL*DIST_W + i] && d < nd_reg && i < SENSOR_COUNT)
                num_next[i] = nd_reg - dc;
            else
                num_next[i] = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            num_reg <= num_next;
    end

    // divider: one restoring step per stage
    logic             dv_reg   [DET_W];
    logic [15:0]      rem_reg  [DET_W][NL];
    logic [DET_W-1:0] q_reg    [DET_W][NL];
    logic [15:0]      rem_next [DET_W][NL];
    logic [DET_W-1:0] q_next   [DET_W][NL];

    for (genvar k = 0; k < DET_W; k++)
    begin : g_div
        logic             v_in;
        logic [16:0]      x_in [NL];
        logic [DET_W-1:0] q_in [NL];

        if (k == 0)
        begin : g_head
            assign v_in = v1_reg;
            for (genvar i = 0; i < NL; i++)
            begin : g_lane
                assign x_in[i] = {1'b0, num_reg[i]};
                assign q_in[i] = '0;
            end
        end
        else
        begin : g_step
            assign v_in = dv_reg[k-1];
            for (genvar i = 0; i < NL; i++)
            begin : g_lane
                assign x_in[i] = {rem_reg[k-1][i], 1'b0};
                assign q_in[i] = q_reg[k-1][i];
            end
        end

        always_comb
        begin
            logic ge;
            ge = 1'b0;
            for (int i = 0; i < NL; i++)
            begin
                ge = span_ok && (x_in[i] >= {1'b0, span});
                rem_next[k][i] = ge ? 16'(x_in[i] - {1'b0, span}) : x_in[i][15:0];
                q_next[k][i]   = {q_in[i][DET_W-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[k] <= 1'b0;
            else if (en)
                dv_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
            end
        end
    end

    // products
    logic                     vp_reg;
    logic signed [PROD_W-1:0] pl_reg [NL];
    logic signed [PROD_W-1:0] pr_reg [NL];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vp_reg <= 1'b0;
        else if (en)
            vp_reg <= dv_reg[DET_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NL; i++)
            begin
                pl_reg[i] <= $signed({{(PROD_W-DET_W){1'b0}}, q_reg[DET_W-1][i]})
                           * PROD_W'(LEFT_WEIGHT[i]);
                pr_reg[i] <= $signed({{(PROD_W-DET_W){1'b0}}, q_reg[DET_W-1][i]})
                           * PROD_W'(RIGHT_WEIGHT[i]);
            end
        end
    end

    // adder tree: halves, then total
    logic                    vs1_reg, vs2_reg;
    logic signed [SUM_W-1:0] hl_reg [2];
    logic signed [SUM_W-1:0] hr_reg [2];
    logic signed [SUM_W-1:0] sl_reg, sr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vs1_reg <= 1'b0;
            vs2_reg <= 1'b0;
        end
        else if (en)
        begin
            vs1_reg <= vp_reg;
            vs2_reg <= vs1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int h = 0; h < 2; h++)
            begin
                hl_reg[h] <= SUM_W'(pl_reg[4*h]) + SUM_W'(pl_reg[4*h+1])
                           + SUM_W'(pl_reg[4*h+2]) + SUM_W'(pl_reg[4*h+3]);
                hr_reg[h] <= SUM_W'(pr_reg[4*h]) + SUM_W'(pr_reg[4*h+1])
                           + SUM_W'(pr_reg[4*h+2]) + SUM_W'(pr_reg[4*h+3]);
            end
            sl_reg <= hl_reg[0] + hl_reg[1];
            sr_reg <= hr_reg[0] + hr_reg[1];
        end
    end

    // round |S|/160: ((|S|+80)>>5) / 5 by reciprocal
    logic        vr_reg;
    logic        negl_reg, negr_reg;
    logic [31:0] ml_reg, mr_reg;
    logic [SUM_W-1:0] magl, magr, adjl, adjr;

    assign magl = sl_reg[SUM_W-1] ? SUM_W'(-sl_reg) : sl_reg;
    assign magr = sr_reg[SUM_W-1] ? SUM_W'(-sr_reg) : sr_reg;
    assign adjl = magl + ROUND_HALF;
    assign adjr = magr + ROUND_HALF;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vr_reg <= 1'b0;
        else if (en)
            vr_reg <= vs2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            negl_reg <= sl_reg[SUM_W-1];
            negr_reg <= sr_reg[SUM_W-1];
            ml_reg   <= {17'd0, adjl[SUM_W-1:5]} * {15'd0, RECIP5};
            mr_reg   <= {17'd0, adjr[SUM_W-1:5]} * {15'd0, RECIP5};
        end
    end

    // threshold, saturation, output register
    logic [12:0]        ql, qr;
    logic signed [16:0] tl, tr;
    logic [15:0]        spl, spr;
    logic               emit;
    logic [31:0]        odata_reg;

    assign ql   = ml_reg[RECIP_SH +: 13];
    assign qr   = mr_reg[RECIP_SH +: 13];
    assign emit = ({2'b0, ql} > thr_reg) || ({2'b0, qr} > thr_reg);
    assign tl   = 17'(base_reg) + (negl_reg ? -$signed({4'b0, ql}) : $signed({4'b0, ql}));
    assign tr   = 17'(base_reg) + (negr_reg ? -$signed({4'b0, qr}) : $signed({4'b0, qr}));

    always_comb
    begin
        if (tl > 17'sd32767)
            spl = 16'h7FFF;
        else if (tl < -17'sd32768)
            spl = 16'h8000;
        else
            spl = tl[15:0];
        if (tr > 17'sd32767)
            spr = 16'h7FFF;
        else if (tr < -17'sd32768)
            spr = 16'h8000;
        else
            spr = tr[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= vr_reg && emit;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            odata_reg <= {spr, spl};
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = odata_reg;

endmodule
